FILE: src/wrg_pkg.sv
// shared constants, types and word functions of the well44497 generator
`default_nettype none

package wrg_pkg;

   localparam int POOL_DEPTH = 1391;
   localparam int ADDR_W     = 11;
   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = 48;

   localparam logic [ADDR_W-1:0] POOL_LEN  = ADDR_W'(POOL_DEPTH);
   localparam logic [ADDR_W-1:0] OFS_A     = ADDR_W'(23);
   localparam logic [ADDR_W-1:0] OFS_B     = ADDR_W'(481);
   localparam logic [ADDR_W-1:0] OFS_C     = ADDR_W'(229);
   localparam logic [ADDR_W-1:0] OFS_M1    = ADDR_W'(POOL_DEPTH - 1);
   localparam logic [ADDR_W-1:0] OFS_M2    = ADDR_W'(POOL_DEPTH - 2);

   localparam logic [WORD_W-1:0] LOW_MASK  = 32'h0000_7fff;
   localparam logic [WORD_W-1:0] HIGH_MASK = 32'hffff_8000;
   localparam logic [WORD_W-1:0] MIX_XOR   = 32'hb729_fcec;
   localparam logic [WORD_W-1:0] MIX_KEEP  = 32'hfbff_ffff;
   localparam logic [WORD_W-1:0] MIX_TEST  = 32'h0002_0000;
   localparam logic [WORD_W-1:0] TEMPER_B  = 32'h93dd_1400;
   localparam logic [WORD_W-1:0] TEMPER_C  = 32'hfa11_8000;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_BC,
      ST_FETCH_Z,
      ST_MIX,
      ST_DONE
   } state_type;

   // which pair of pool words the two read ports fetch
   typedef enum logic [1:0] {
      RD_P_A,
      RD_B_C,
      RD_M1_M2
   } rd_sel_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      logic       load;
      logic       cap_pa;
      logic       cap_bc;
      logic       mix;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] ofs);
      logic [ADDR_W:0] s;
      s = {1'b0, base} + {1'b0, ofs};
      if (s >= {1'b0, POOL_LEN}) begin
         s = s - {1'b0, POOL_LEN};
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] mix_rot(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = {v[22:0], v[31:23]} & MIX_KEEP;
      if ((v & MIX_TEST) != '0) begin
         r = r ^ MIX_XOR;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] y;
      y = v ^ ((v << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      return y;
   endfunction

endpackage

`default_nettype wire

FILE: src/wrg_ram.sv
// generic ram: one write port, two read ports with registered data
`default_nettype none

module wrg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr_a,
   input  wire logic [AddrW-1:0] rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: src/wrg_ctrl.sv
// sequencer for seed loads and draws
`default_nettype none

module wrg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_tuser,
   input  wire wrg_pkg::status_type status,
   output wrg_pkg::cmd_type         cmd
);

   wrg_pkg::state_type state_ff, state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      cmd        = '0;
      cmd.rd_sel = wrg_pkg::RD_P_A;
      unique case (state_ff)
         wrg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               if (req_tuser == wrg_pkg::KIND_DRAW) begin
                  state_in = wrg_pkg::ST_FETCH_BC;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         wrg_pkg::ST_FETCH_BC: begin
            cmd.cap_pa = 1'b1;
            cmd.rd_sel = wrg_pkg::RD_B_C;
            state_in   = wrg_pkg::ST_FETCH_Z;
         end
         wrg_pkg::ST_FETCH_Z: begin
            cmd.cap_bc = 1'b1;
            cmd.rd_sel = wrg_pkg::RD_M1_M2;
            state_in   = wrg_pkg::ST_MIX;
         end
         wrg_pkg::ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = wrg_pkg::ST_DONE;
         end
         wrg_pkg::ST_DONE: begin
            // hold here until the result register is free
            if (!status.out_busy) begin
               cmd.fin  = 1'b1;
               state_in = wrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrg_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> !status.out_busy)
      else $error("result loaded while previous beat still pending");
   a_mix_then_done: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |=> state_ff == wrg_pkg::ST_DONE)
      else $error("mix not followed by done");
   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == wrg_pkg::KIND_DRAW) |=> cmd.cap_pa)
      else $error("draw did not start fetching");
`endif

endmodule

`default_nettype wire

FILE: src/wrg_datapath.sv
// pool memory, read address generation, well transform and result register
`default_nettype none

module wrg_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire wrg_pkg::cmd_type                 cmd,
   output wrg_pkg::status_type                   status,
   input  wire logic [wrg_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [wrg_pkg::WORD_W-1:0]       rsp_tdata
);

   logic [wrg_pkg::ADDR_W-1:0] position_ff, position_in;
   logic [wrg_pkg::ADDR_W-1:0] addr_a, addr_b, addr_c, addr_m1, addr_m2;
   logic [wrg_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic [wrg_pkg::ADDR_W-1:0] seed_index;
   logic [wrg_pkg::WORD_W-1:0] seed_word;
   logic [wrg_pkg::WORD_W-1:0] rd_data_a, rd_data_b, wr_data;
   logic                       wr_en;

   logic [wrg_pkg::WORD_W-1:0] v0_ff, va_ff, vb_ff, vc_ff, n0_ff, sample_ff;
   logic                       valid_ff, valid_in;
   logic [wrg_pkg::WORD_W-1:0] z0, z1, z2, n1, n0;

   assign seed_index = req_tdata[wrg_pkg::ADDR_W-1:0];
   assign seed_word  = req_tdata[wrg_pkg::ADDR_W +: wrg_pkg::WORD_W];

   assign addr_a  = wrg_pkg::wrap_add(position_ff, wrg_pkg::OFS_A);
   assign addr_b  = wrg_pkg::wrap_add(position_ff, wrg_pkg::OFS_B);
   assign addr_c  = wrg_pkg::wrap_add(position_ff, wrg_pkg::OFS_C);
   assign addr_m1 = wrg_pkg::wrap_add(position_ff, wrg_pkg::OFS_M1);
   assign addr_m2 = wrg_pkg::wrap_add(position_ff, wrg_pkg::OFS_M2);

   always_comb begin
      unique case (cmd.rd_sel)
         wrg_pkg::RD_P_A: begin
            rd_addr_a = position_ff;
            rd_addr_b = addr_a;
         end
         wrg_pkg::RD_B_C: begin
            rd_addr_a = addr_b;
            rd_addr_b = addr_c;
         end
         wrg_pkg::RD_M1_M2: begin
            rd_addr_a = addr_m1;
            rd_addr_b = addr_m2;
         end
         default: begin
            rd_addr_a = position_ff;
            rd_addr_b = addr_a;
         end
      endcase
   end

   // mix step: read ports now carry the words at p-1 and p-2
   always_comb begin
      z0 = (rd_data_a & wrg_pkg::HIGH_MASK) | (rd_data_b & wrg_pkg::LOW_MASK);
      z1 = (v0_ff ^ (v0_ff << 24)) ^ (va_ff ^ (va_ff >> 30));
      z2 = (vb_ff ^ (vb_ff << 10)) ^ (vc_ff << 26);
      n1 = z1 ^ z2;
      n0 = z0 ^ (z1 ^ (z1 >> 20)) ^ wrg_pkg::mix_rot(z2) ^ n1;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = position_ff;
      wr_data = n1;
      if (cmd.load) begin
         wr_en   = seed_index < wrg_pkg::POOL_LEN;
         wr_addr = seed_index;
         wr_data = seed_word;
      end else if (cmd.mix) begin
         wr_en = 1'b1;
      end else if (cmd.fin) begin
         wr_en   = 1'b1;
         wr_addr = addr_m1;
         wr_data = n0_ff;
      end
   end

   wrg_ram #(
      .WIDTH(wrg_pkg::WORD_W),
      .DEPTH(wrg_pkg::POOL_DEPTH)
   ) u_pool (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   always_comb begin
      position_in = position_ff;
      if (cmd.load) begin
         position_in = '0;
      end else if (cmd.fin) begin
         position_in = addr_m1;
      end
      valid_in = valid_ff && !rsp_tready;
      if (cmd.fin) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         position_ff <= position_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_pa) begin
         v0_ff <= rd_data_a;
         va_ff <= rd_data_b;
      end
      if (cmd.cap_bc) begin
         vb_ff <= rd_data_a;
         vc_ff <= rd_data_b;
      end
      if (cmd.mix) begin
         n0_ff <= n0;
      end
      if (cmd.fin) begin
         sample_ff <= wrg_pkg::temper(n0_ff);
      end
   end

   assign status.out_busy = valid_ff && !rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = sample_ff;

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position_ff < wrg_pkg::POOL_LEN)
      else $error("position out of pool range");
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr < wrg_pkg::POOL_LEN)
      else $error("pool write outside range");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_tvalid && position_ff == $past(addr_m1))
      else $error("draw finish did not post result and step position");
`endif

endmodule

`default_nettype wire

FILE: src/well44497_random_generator.sv
// top level of the well44497b random word generator
//
//   channel  | dir | tdata (low bit up)               | tuser
//   req_*    | in  | seed_index[10:0], seed_word[42:11] | kind (0 load, 1 draw)
//   rsp_*    | out | sample[31:0]                     | -
//
// a seed load gives no beat
// a draw holds req_tready low until it is done: six pool reads go
// through the two read ports of the pool ram in pairs, then two writes
// a result waits in an output register; a draw stalls only in its done state
// if the previous beat has not been taken
// reset clears position to 0; pool contents are undefined until loaded
`default_nettype none

module well44497_random_generator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [wrg_pkg::REQ_DATA_W-1:0] req_tdata,  // seed_index, seed_word, zero pad
   input  wire logic                           req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [wrg_pkg::WORD_W-1:0]     rsp_tdata   // sample
);

   wrg_pkg::cmd_type    cmd;
   wrg_pkg::status_type status;

   wrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   wrg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: tb/wrg_checker.sv
// scoreboard for the well44497 generator: predicts each sample and compares the result beats
module wrg_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [wrg_pkg::REQ_DATA_W-1:0] req_tdata,   // seed_index, seed_word, zero pad
   input  logic                           req_tuser,   // kind
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wrg_pkg::WORD_W-1:0]     rsp_tdata,   // sample
   output int                             fault_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_LEN   = wrg_pkg::POOL_DEPTH;
   localparam int SEED_LSB   = wrg_pkg::ADDR_W;
   localparam int REPORT_MAX = 10;

   localparam logic [31:0] UPPER_BITS = 32'hffff_8000;
   localparam logic [31:0] LOWER_BITS = 32'h0000_7fff;
   localparam logic [31:0] ROT_XOR    = 32'hb729_fcec;
   localparam logic [31:0] ROT_KEEP   = 32'hfbff_ffff;
   localparam logic [31:0] SHAPE_B    = 32'h93dd_1400;
   localparam logic [31:0] SHAPE_C    = 32'hfa11_8000;

   logic [31:0] ring_words [RING_LEN];
   logic [10:0] ring_pos;
   logic [31:0] sample_fifo [$];

   function automatic int ring_at(input int base, input int ofs);
      return (base + ofs) % RING_LEN;
   endfunction

   initial begin
      fault_count = 0;
      pending     = 0;
   end

   always @(posedge clock) begin : watch
      int          p;
      logic [10:0] seed_idx;
      logic [31:0] v0, va, vb, vc, z0, z1, z2, rot, n0, n1, shaped, want;

      if (reset) begin
         ring_pos = '0;
         sample_fifo.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sample_fifo.size() == 0) begin
               if (fault_count < REPORT_MAX)
                  $display("%0t: sample beat %h with nothing expected", $realtime, rsp_tdata);
               fault_count <= fault_count + 1;
            end else begin
               want = sample_fifo.pop_front();
               if (rsp_tdata !== want) begin
                  if (fault_count < REPORT_MAX)
                     $display("%0t: sample mismatch, expected %h, got %h",
                              $realtime, want, rsp_tdata);
                  fault_count <= fault_count + 1;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == wrg_pkg::KIND_LOAD) begin
               seed_idx = req_tdata[SEED_LSB-1:0];
               // out-of-range index writes nothing but still rewinds
               if (seed_idx < RING_LEN)
                  ring_words[seed_idx] = req_tdata[SEED_LSB+31:SEED_LSB];
               ring_pos = '0;
            end else begin
               p  = ring_pos;
               v0 = ring_words[p];
               va = ring_words[ring_at(p, 23)];
               vb = ring_words[ring_at(p, 481)];
               vc = ring_words[ring_at(p, 229)];
               z0 = (ring_words[ring_at(p, RING_LEN - 1)] & UPPER_BITS)
                  | (ring_words[ring_at(p, RING_LEN - 2)] & LOWER_BITS);
               z1 = v0 ^ (v0 << 24) ^ va ^ (va >> 30);
               z2 = vb ^ (vb << 10) ^ (vc << 26);
               n1 = z1 ^ z2;
               rot = ((z2 << 9) | (z2 >> 23)) & ROT_KEEP;
               if (z2[17])
                  rot = rot ^ ROT_XOR;
               n0 = z0 ^ z1 ^ (z1 >> 20) ^ rot ^ n1;
               ring_words[p] = n1;
               ring_words[ring_at(p, RING_LEN - 1)] = n0;
               ring_pos = 11'(ring_at(p, RING_LEN - 1));
               shaped = n0 ^ ((n0 << 7) & SHAPE_B);
               shaped = shaped ^ ((shaped << 15) & SHAPE_C);
               sample_fifo.push_back(shaped);
            end
         end
         pending <= sample_fifo.size();
      end
   end

endmodule

FILE: tb/tb_well44497_random_generator.sv
// testbench top for the well44497 generator: seeding and draw stimulus, receiver stalls, verdict
module tb_well44497_random_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_LEN     = wrg_pkg::POOL_DEPTH;
   localparam int PAD_W        = wrg_pkg::REQ_DATA_W - wrg_pkg::ADDR_W - wrg_pkg::WORD_W;
   localparam int RANDOM_ITEMS = 940;
   localparam int CHAIN_MAX    = 24;
   localparam int QUIET_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 16;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [wrg_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // seed_index, seed_word, zero pad
   logic                           req_tuser  = 1'b0; // kind
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [wrg_pkg::WORD_W-1:0]     rsp_tdata;         // sample

   int fault_count;
   int pending;
   int burst_left   = 0;
   int quiet_cycles = 0;
   int rx_mode      = 0;
   int rx_span      = 0;
   int unsigned rx_tick = 0;

   always #4 clock = ~clock;

   well44497_random_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wrg_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fault_count (fault_count),
      .pending     (pending)
   );

   // receiver: switches between always ready, coin flip, heavy stall and a fixed duty pattern
   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_span = $urandom_range(16, 160);
      end
      rx_span = rx_span - 1;
      rx_tick = rx_tick + 1;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ((rx_tick % 5) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request beat; called at the step of the previous handshake
   task automatic push_item(input logic kind, input logic [10:0] idx, input logic [31:0] word);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{PAD_W{1'b0}}, word, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
   endtask

   // random seed words for pool entries lo..hi
   task automatic seed_span(input int lo, input int hi);
      for (int i = lo; i <= hi; i++)
         push_item(wrg_pkg::KIND_LOAD, 11'(i), $urandom);
   endtask

   // hold the sender until every predicted sample has come back
   task automatic drain_samples();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [10:0] idx;
      int          chain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out-of-range seeds change nothing but the position
      push_item(wrg_pkg::KIND_LOAD, 11'd1391, 32'h1234_5678);
      push_item(wrg_pkg::KIND_LOAD, 11'd2047, 32'hffff_ffff);
      // every word the first draw from position zero touches
      push_item(wrg_pkg::KIND_LOAD, 11'd0,    32'h0000_0000);
      push_item(wrg_pkg::KIND_LOAD, 11'd23,   32'hffff_ffff);
      push_item(wrg_pkg::KIND_LOAD, 11'd481,  32'h0002_0000);
      push_item(wrg_pkg::KIND_LOAD, 11'd229,  32'h8000_0001);
      push_item(wrg_pkg::KIND_LOAD, 11'd1390, 32'hffff_8000);
      push_item(wrg_pkg::KIND_LOAD, 11'd1389, 32'h0000_7fff);
      // draw ignores its seed fields; position wraps from zero to the top
      push_item(wrg_pkg::KIND_DRAW, 11'd2047, 32'hffff_ffff);
      push_item(wrg_pkg::KIND_LOAD, 11'd0,    32'hdead_beef);
      push_item(wrg_pkg::KIND_DRAW, 11'd0,    32'h0000_0000);
      push_item(wrg_pkg::KIND_LOAD, 11'd1391, 32'h0000_0000);
      push_item(wrg_pkg::KIND_DRAW, 11'd1024, 32'haaaa_5555);
      drain_samples();

      // seed every word that a chain of up to CHAIN_MAX draws from position zero reads
      seed_span(RING_LEN - CHAIN_MAX - 1, RING_LEN - 1);
      seed_span(0, 23);
      seed_span(229 - CHAIN_MAX + 1, 229);
      seed_span(481 - CHAIN_MAX + 1, 481);

      chain = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a load rewinds the position, so long chains are cut before leaving seeded words
         if (chain == CHAIN_MAX || $urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 4) == 0)
               idx = 11'($urandom_range(RING_LEN, 2047));
            else
               idx = 11'($urandom_range(0, RING_LEN - 1));
            push_item(wrg_pkg::KIND_LOAD, idx, $urandom);
            chain = 0;
         end else begin
            push_item(wrg_pkg::KIND_DRAW, 11'($urandom), $urandom);
            chain = chain + 1;
         end
         if (n == RANDOM_ITEMS / 2)
            drain_samples();
      end

      drain_samples();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
src/wrg_pkg.sv
src/wrg_ram.sv
src/wrg_ctrl.sv
src/wrg_datapath.sv
src/well44497_random_generator.sv
tb/wrg_checker.sv
tb/tb_well44497_random_generator.sv
